// ----- rtl/core/iwd_pkg.sv -----
// ----------------------------------------------------------------------------
// iwd_pkg
// Shared types and constants of the instruction word decoder: format table,
// result kinds, second operand forms and the packed result layout.
// ----------------------------------------------------------------------------
package iwd_pkg;

    localparam int WORD_W   = 32;
    localparam int FMT_COUNT = 15;
    localparam int FMT_W    = 4;

    // format table, highest priority first
    localparam logic [WORD_W-1:0] FMT_MASK [FMT_COUNT] = '{
        32'h0FFF_FFF0, 32'h0FB0_0FF0, 32'h0FC0_00F0, 32'h0E40_0F90, 32'h0F80_00F0,
        32'h0E40_0090, 32'h0F00_0010, 32'h0F00_0010, 32'h0E00_0010, 32'h0F00_0000,
        32'h0E00_0000, 32'h0E00_0000, 32'h0E00_0000, 32'h0C00_0000, 32'h0C00_0000
    };
    localparam logic [WORD_W-1:0] FMT_MATCH [FMT_COUNT] = '{
        32'h012F_FF10, 32'h0100_0090, 32'h0000_0090, 32'h0000_0090, 32'h0080_0090,
        32'h0040_0090, 32'h0E00_0000, 32'h0E00_0010, 32'h0600_0010, 32'h0F00_0000,
        32'h0800_0000, 32'h0A00_0000, 32'h0C00_0000, 32'h0000_0000, 32'h0400_0000
    };

    localparam logic [FMT_W-1:0] FMT_BX       = 4'd0;
    localparam logic [FMT_W-1:0] FMT_BRANCH   = 4'd11;
    localparam logic [FMT_W-1:0] FMT_DATAPROC = 4'd13;

    // result kinds
    localparam logic [3:0] KIND_DATAPROC     = 4'd0;
    localparam logic [3:0] KIND_MRS_CPSR     = 4'd1;
    localparam logic [3:0] KIND_MRS_SPSR     = 4'd2;
    localparam logic [3:0] KIND_MSR_CPSR     = 4'd3;
    localparam logic [3:0] KIND_MSR_CPSR_FLG = 4'd4;
    localparam logic [3:0] KIND_MSR_SPSR     = 4'd5;
    localparam logic [3:0] KIND_MSR_SPSR_FLG = 4'd6;
    localparam logic [3:0] KIND_BRANCH       = 4'd7;
    localparam logic [3:0] KIND_BX           = 4'd8;
    localparam logic [3:0] KIND_NOT_IMPL     = 4'd9;

    // alu opcodes that turn into psr transfers when S is clear
    localparam logic [3:0] OP_TST = 4'd8;
    localparam logic [3:0] OP_TEQ = 4'd9;
    localparam logic [3:0] OP_CMP = 4'd10;
    localparam logic [3:0] OP_CMN = 4'd11;

    localparam logic [3:0] PSR_FLAGS_FIELD = 4'd8;

    // second operand forms
    localparam logic [3:0] OPF_ROT_IMM   = 4'd0;
    localparam logic [3:0] OPF_IMM_SHIFT = 4'd1;  // plus shift type
    localparam logic [3:0] OPF_REG_SHIFT = 4'd5;  // plus shift type
    localparam logic [3:0] OPF_RRX       = 4'd9;

    localparam logic [1:0] SHIFT_LSL = 2'd0;
    localparam logic [1:0] SHIFT_LSR = 2'd1;
    localparam logic [1:0] SHIFT_ASR = 2'd2;
    localparam logic [1:0] SHIFT_ROR = 2'd3;

    localparam logic [5:0] SHIFT_BY_32 = 6'd32;

    // decoded result, first field in the highest bits
    typedef struct packed {
        logic signed [25:0] branch_offset;
        logic [5:0]         operand_amount;
        logic [7:0]         operand_value;
        logic [3:0]         operand_form;
        logic [3:0]         first_reg;
        logic [3:0]         dest_reg;
        logic               link;
        logic               set_flags;
        logic [3:0]         alu_opcode;
        logic [3:0]         cond_code;
        logic [FMT_W-1:0]   format_index;
        logic [3:0]         kind;
    } dec_out_t;

    localparam int OUT_W   = $bits(dec_out_t);
    localparam int OUT_PAD = ((OUT_W + 7) / 8) * 8 - OUT_W;

endpackage

// ----- rtl/core/instruction_word_decoder_unit.sv -----
// ----------------------------------------------------------------------------
// instruction_word_decoder_unit
// Pipelined decoder of 32-bit A32 (v4T) instruction words.
// ----------------------------------------------------------------------------
// Takes one instruction word per transfer and returns one decoded result per
// word, in order. Branch-and-exchange, branch and data processing (including
// PSR transfers) are decoded fully; every other format returns the
// not-implemented kind with only format index and condition filled in.
// The pipeline is four registers deep: the input word register, then the
// table compare, the priority select and the field decode, each of which
// ends in a register, the last one being the output register. A new word is
// taken every clock cycle while the output side does not stall.
// Each stage holds its word while the stage after it is full, so a stall on
// the output backs up stage by stage and nothing is dropped or repeated.
module instruction_word_decoder_unit
    import iwd_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,

    input  logic                      s_axis_tvalid,
    output logic                      s_axis_tready,
    input  logic [WORD_W-1:0]         s_axis_tdata,   // instr_word

    output logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    // kind, format_index, cond_code, alu_opcode, set_flags, link, dest_reg,
    // first_reg, operand_form, operand_value, operand_amount, branch_offset
    output logic [OUT_W+OUT_PAD-1:0]  m_axis_tdata
);

    logic                 v1_reg, v2_reg, v3_reg, out_valid_reg;
    logic                 rdy1, rdy2, rdy3;
    logic [WORD_W-1:0]    w1_reg, w2_reg, w3_reg;
    logic [FMT_COUNT-1:0] match_reg, match_next;
    logic [FMT_W-1:0]     fmt_reg, fmt_next;
    dec_out_t             out_reg, dec_next;

    // a stage moves on when the next one is empty or moving too
    assign rdy3          = !out_valid_reg || m_axis_tready;
    assign rdy2          = !v3_reg || rdy3;
    assign rdy1          = !v2_reg || rdy2;
    assign s_axis_tready = !v1_reg || rdy1;

    // format table compare
    always_comb
    begin
        for (int i = 0; i < FMT_COUNT; i++)
        begin
            match_next[i] = (w1_reg & FMT_MASK[i]) == FMT_MATCH[i];
        end
    end

    // first match wins
    always_comb
    begin
        fmt_next = FMT_W'(FMT_COUNT - 1);
        for (int i = FMT_COUNT - 1; i >= 0; i--)
        begin
            if (match_reg[i])
            begin
                fmt_next = FMT_W'(i);
            end
        end
    end

    // field decode
    always_comb
    begin
        logic [3:0] op;
        logic       s_bit;
        logic [1:0] sh_type;
        logic [4:0] sh_amt;
        logic [3:0] opd_form;
        logic [7:0] opd_value;
        logic [5:0] opd_amount;

        op      = w3_reg[24:21];
        s_bit   = w3_reg[20];
        sh_type = w3_reg[6:5];
        sh_amt  = w3_reg[11:7];

        // second operand
        if (w3_reg[25])
        begin
            opd_form   = OPF_ROT_IMM;
            opd_value  = w3_reg[7:0];
            opd_amount = {1'b0, w3_reg[11:8], 1'b0};
        end
        else if (w3_reg[4])
        begin
            opd_form   = OPF_REG_SHIFT + {2'b00, sh_type};
            opd_value  = {4'h0, w3_reg[3:0]};
            opd_amount = {2'b00, w3_reg[11:8]};
        end
        else
        begin
            opd_form   = OPF_IMM_SHIFT + {2'b00, sh_type};
            opd_value  = {4'h0, w3_reg[3:0]};
            opd_amount = {1'b0, sh_amt};
            if (sh_amt == 5'd0)
            begin
                case (sh_type)
                    SHIFT_LSR, SHIFT_ASR: opd_amount = SHIFT_BY_32;
                    SHIFT_ROR:
                    begin
                        opd_form   = OPF_RRX;
                        opd_amount = '0;
                    end
                    default: ;
                endcase
            end
        end

        dec_next              = '0;
        dec_next.format_index = fmt_reg;
        dec_next.cond_code    = w3_reg[31:28];

        unique case (fmt_reg)
            FMT_BX:
            begin
                dec_next.kind     = KIND_BX;
                dec_next.dest_reg = w3_reg[3:0];
            end
            FMT_BRANCH:
            begin
                dec_next.kind          = KIND_BRANCH;
                dec_next.link          = w3_reg[24];
                dec_next.branch_offset = {w3_reg[23:0], 2'b00};
            end
            FMT_DATAPROC:
            begin
                if (!s_bit && (op == OP_TST || op == OP_CMP))
                begin
                    dec_next.kind     = (op == OP_CMP) ? KIND_MRS_SPSR : KIND_MRS_CPSR;
                    dec_next.dest_reg = w3_reg[15:12];
                end
                else if (!s_bit && (op == OP_TEQ || op == OP_CMN))
                begin
                    if (op == OP_CMN)
                    begin
                        dec_next.kind = (w3_reg[19:16] == PSR_FLAGS_FIELD)
                                        ? KIND_MSR_SPSR_FLG : KIND_MSR_SPSR;
                    end
                    else
                    begin
                        dec_next.kind = (w3_reg[19:16] == PSR_FLAGS_FIELD)
                                        ? KIND_MSR_CPSR_FLG : KIND_MSR_CPSR;
                    end
                    dec_next.operand_form   = opd_form;
                    dec_next.operand_value  = opd_value;
                    dec_next.operand_amount = opd_amount;
                end
                else
                begin
                    dec_next.kind           = KIND_DATAPROC;
                    dec_next.alu_opcode     = op;
                    dec_next.set_flags      = s_bit;
                    dec_next.dest_reg       = w3_reg[15:12];
                    dec_next.first_reg      = w3_reg[19:16];
                    dec_next.operand_form   = opd_form;
                    dec_next.operand_value  = opd_value;
                    dec_next.operand_amount = opd_amount;
                end
            end
            default:
            begin
                dec_next.kind = KIND_NOT_IMPL;
            end
        endcase
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_axis_tready)
            begin
                v1_reg <= s_axis_tvalid;
            end
            if (rdy1)
            begin
                v2_reg <= v1_reg;
            end
            if (rdy2)
            begin
                v3_reg <= v2_reg;
            end
            if (rdy3)
            begin
                out_valid_reg <= v3_reg;
            end
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            w1_reg <= s_axis_tdata;
        end
        if (rdy1 && v1_reg)
        begin
            w2_reg    <= w1_reg;
            match_reg <= match_next;
        end
        if (rdy2 && v2_reg)
        begin
            w3_reg  <= w2_reg;
            fmt_reg <= fmt_next;
        end
        if (rdy3 && v3_reg)
        begin
            out_reg <= dec_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{OUT_PAD{1'b0}}, out_reg};

`ifndef NO_ASSERTIONS
    // a full pipeline with a stalled output takes no new word
    assert property (@(posedge clk) disable iff (!rst_n)
        (v1_reg && v2_reg && v3_reg && out_valid_reg && !m_axis_tready) |-> !s_axis_tready)
        else $error("input taken while pipeline is full and stalled");

    // format index stays inside the table
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (out_reg.format_index < FMT_W'(FMT_COUNT)))
        else $error("format index out of range");

    // branch kinds agree with the selected format
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && (out_reg.kind == KIND_BX || out_reg.kind == KIND_BRANCH))
        |-> (out_reg.format_index == FMT_BX || out_reg.format_index == FMT_BRANCH))
        else $error("branch kind on a non-branch format");

    // not-implemented results carry nothing beyond format and condition
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && out_reg.kind == KIND_NOT_IMPL)
        |-> (m_axis_tdata[OUT_W-1:12] == '0))
        else $error("not-implemented result has stray fields");
`endif

endmodule
